// ----- design/prt_pkg.sv -----
// Shared types, constants and the arctangent table of the planar rigid transform unit.
`timescale 1ns / 1ps

package prt_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int ATAN_IDX_W        = 5;

    // Initial x of the rotation: the CORDIC gain 0.60725... in Q2.30.
    localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;

    typedef enum logic [1:0] {
        OP_APPLY    = 2'd0,
        OP_RELATIVE = 2'd1,
        OP_INVERT   = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    // Operands and early results that ride along the rotation pipeline.
    typedef struct packed {
        opcode_t            op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [15:0]        angle;
        logic               flip;
    } item_t;

    // Arctangent of 2^-i in 32-bit binary-angle units.
    function automatic logic signed [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [31:0] val;
        unique case (idx)
            5'd0:    val = 32'sh20000000;
            5'd1:    val = 32'sh12E4051E;
            5'd2:    val = 32'sh09FB385B;
            5'd3:    val = 32'sh051111D4;
            5'd4:    val = 32'sh028B0D43;
            5'd5:    val = 32'sh0145D7E1;
            5'd6:    val = 32'sh00A2F61E;
            5'd7:    val = 32'sh00517C55;
            5'd8:    val = 32'sh0028BE53;
            5'd9:    val = 32'sh00145F2F;
            5'd10:   val = 32'sh000A2F98;
            5'd11:   val = 32'sh000517CC;
            5'd12:   val = 32'sh00028BE6;
            5'd13:   val = 32'sh000145F3;
            5'd14:   val = 32'sh0000A2FA;
            5'd15:   val = 32'sh0000517D;
            5'd16:   val = 32'sh000028BE;
            5'd17:   val = 32'sh0000145F;
            5'd18:   val = 32'sh00000A30;
            5'd19:   val = 32'sh00000518;
            5'd20:   val = 32'sh0000028C;
            5'd21:   val = 32'sh00000146;
            5'd22:   val = 32'sh000000A3;
            5'd23:   val = 32'sh00000051;
            default: val = 32'sh00000000;
        endcase
        return val;
    endfunction

endpackage

// ----- design/prt_cordic.sv -----
// Unrolled CORDIC rotation pipeline, one register stage per micro-rotation.
`timescale 1ns / 1ps

module prt_cordic #(
    parameter int STAGES = prt_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] in_z,
    input  prt_pkg::item_t     in_item,
    output logic               out_valid,
    output logic signed [31:0] out_cos,
    output logic signed [31:0] out_sin,
    output prt_pkg::item_t     out_item
);

    logic signed [31:0] x_src    [STAGES];
    logic signed [31:0] y_src    [STAGES];
    logic signed [31:0] z_src    [STAGES];
    logic               v_src    [STAGES];
    prt_pkg::item_t     item_src [STAGES];

    logic signed [31:0] x_next [STAGES];
    logic signed [31:0] y_next [STAGES];
    logic signed [31:0] z_next [STAGES];

    logic signed [31:0] x_reg    [STAGES];
    logic signed [31:0] y_reg    [STAGES];
    logic signed [31:0] z_reg    [STAGES];
    logic               v_reg    [STAGES];
    prt_pkg::item_t     item_reg [STAGES];

    for (genvar gi = 0; gi < STAGES; gi++)
    begin : g_stage
        if (gi == 0)
        begin : g_first
            assign x_src[gi]    = prt_pkg::CORDIC_GAIN;
            assign y_src[gi]    = '0;
            assign z_src[gi]    = in_z;
            assign v_src[gi]    = in_valid;
            assign item_src[gi] = in_item;
        end
        else
        begin : g_rest
            assign x_src[gi]    = x_reg[gi-1];
            assign y_src[gi]    = y_reg[gi-1];
            assign z_src[gi]    = z_reg[gi-1];
            assign v_src[gi]    = v_reg[gi-1];
            assign item_src[gi] = item_reg[gi-1];
        end

        // A zero residual angle counts as positive; shifts round toward minus infinity.
        always_comb
        begin
            if (!z_src[gi][31])
            begin
                x_next[gi] = x_src[gi] - (y_src[gi] >>> gi);
                y_next[gi] = y_src[gi] + (x_src[gi] >>> gi);
                z_next[gi] = z_src[gi] - prt_pkg::atan_entry(prt_pkg::ATAN_IDX_W'(gi));
            end
            else
            begin
                x_next[gi] = x_src[gi] + (y_src[gi] >>> gi);
                y_next[gi] = y_src[gi] - (x_src[gi] >>> gi);
                z_next[gi] = z_src[gi] + prt_pkg::atan_entry(prt_pkg::ATAN_IDX_W'(gi));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[gi] <= 1'b0;
            end
            else
            begin
                v_reg[gi] <= v_src[gi];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[gi]    <= x_next[gi];
            y_reg[gi]    <= y_next[gi];
            z_reg[gi]    <= z_next[gi];
            item_reg[gi] <= item_src[gi];
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_cos   = x_reg[STAGES-1];
    assign out_sin   = y_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];

endmodule

// ----- design/planar_rigid_transform_unit.sv -----
// Top level of the planar rigid transform unit: entry stage, rotation, products and output.
`timescale 1ns / 1ps

// Planar rigid-motion unit. A transaction is accepted at a rising edge with start high;
// busy is always low, so a new transaction may enter in every cycle. The opcode picks
// apply A to B, the transform between poses A and B, or the inverse of A. Positions
// are signed Q16.16, angles are 16-bit binary angles that wrap modulo one turn.
// done rises once a transaction has passed one entry stage, one stage per CORDIC
// micro-rotation, then product, sum, rounding and offset/clip stages. Throughput
// is one transaction per cycle; the unrolled rotation pipeline sets the depth.
// Each result is shown on out_x, out_y, out_angle and saturated for exactly one cycle
// with done high. The receiver cannot stall, so nothing is held back or queued.
// Reset clears every valid bit; transactions in flight at reset are dropped and no
// strobe follows them. Opcode 3 returns a result with all fields zero.
module planar_rigid_transform_unit #(
    parameter int CORDIC_STAGES = prt_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic [15:0]        a_angle,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic [15:0]        b_angle,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic [15:0]        out_angle,
    output logic               saturated
);

    localparam int NUM_STAGES = (CORDIC_STAGES > prt_pkg::ATAN_ENTRIES) ?
                                prt_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam int LATENCY    = NUM_STAGES + 5;

    localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;

    assign busy = 1'b0;

    // ---------------- entry stage ----------------
    prt_pkg::opcode_t   op_in;
    logic [15:0]        rot_angle;
    logic [15:0]        res_angle;
    logic               flip_in;
    prt_pkg::item_t     item_next;
    logic signed [31:0] z_next;

    logic               s0_valid_reg;
    prt_pkg::item_t     s0_item_reg;
    logic signed [31:0] s0_z_reg;

    always_comb
    begin
        op_in     = prt_pkg::opcode_t'(opcode);
        rot_angle = (op_in == prt_pkg::OP_RELATIVE) ? (b_angle - a_angle) : a_angle;
        unique case (op_in)
            prt_pkg::OP_APPLY:    res_angle = a_angle + b_angle;
            prt_pkg::OP_RELATIVE: res_angle = b_angle - a_angle;
            prt_pkg::OP_INVERT:   res_angle = 16'd0 - a_angle;
            default:              res_angle = 16'd0;
        endcase
        // Second and third quadrants are turned by half a turn, so the top bit of
        // the folded angle equals bit 14 of the original.
        flip_in = rot_angle[15] ^ rot_angle[14];
        z_next  = {rot_angle[14], rot_angle[14:0], 16'h0000};

        item_next.op    = op_in;
        item_next.ax    = a_x;
        item_next.ay    = a_y;
        item_next.bx    = b_x;
        item_next.by    = b_y;
        item_next.angle = res_angle;
        item_next.flip  = flip_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_item_reg <= item_next;
        s0_z_reg    <= z_next;
    end

    // ---------------- rotation ----------------
    logic               cr_valid;
    logic signed [31:0] cr_cos;
    logic signed [31:0] cr_sin;
    prt_pkg::item_t     cr_item;

    prt_cordic #(
        .STAGES (NUM_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_z      (s0_z_reg),
        .in_item   (s0_item_reg),
        .out_valid (cr_valid),
        .out_cos   (cr_cos),
        .out_sin   (cr_sin),
        .out_item  (cr_item)
    );

    // ---------------- product stage ----------------
    logic signed [31:0] px;
    logic signed [31:0] py;

    logic               pr_valid_reg;
    prt_pkg::item_t     pr_item_reg;
    logic signed [63:0] pxc_reg;
    logic signed [63:0] pys_reg;
    logic signed [63:0] pxs_reg;
    logic signed [63:0] pyc_reg;

    always_comb
    begin
        if (cr_item.op == prt_pkg::OP_APPLY)
        begin
            px = cr_item.bx;
            py = cr_item.by;
        end
        else
        begin
            px = cr_item.ax;
            py = cr_item.ay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
        end
        else
        begin
            pr_valid_reg <= cr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_item_reg <= cr_item;
        pxc_reg     <= 64'(px * cr_cos);
        pys_reg     <= 64'(py * cr_sin);
        pxs_reg     <= 64'(px * cr_sin);
        pyc_reg     <= 64'(py * cr_cos);
    end

    // ---------------- sum stage ----------------
    logic signed [65:0] pxc_w;
    logic signed [65:0] pys_w;
    logic signed [65:0] pxs_w;
    logic signed [65:0] pyc_w;
    logic signed [65:0] sum_x_next;
    logic signed [65:0] sum_y_next;

    logic               sm_valid_reg;
    prt_pkg::item_t     sm_item_reg;
    logic signed [65:0] sum_x_reg;
    logic signed [65:0] sum_y_reg;

    // A folded angle negates both cosine and sine, which negates every sum.
    always_comb
    begin
        pxc_w = 66'(pxc_reg);
        pys_w = 66'(pys_reg);
        pxs_w = 66'(pxs_reg);
        pyc_w = 66'(pyc_reg);
        if (pr_item_reg.op == prt_pkg::OP_INVERT)
        begin
            sum_x_next = pr_item_reg.flip ? (pxc_w + pys_w) : (-pxc_w - pys_w);
            sum_y_next = pr_item_reg.flip ? (pyc_w - pxs_w) : (pxs_w - pyc_w);
        end
        else
        begin
            sum_x_next = pr_item_reg.flip ? (pys_w - pxc_w) : (pxc_w - pys_w);
            sum_y_next = pr_item_reg.flip ? (-pxs_w - pyc_w) : (pxs_w + pyc_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_valid_reg <= 1'b0;
        end
        else
        begin
            sm_valid_reg <= pr_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sm_item_reg <= pr_item_reg;
        sum_x_reg   <= sum_x_next;
        sum_y_reg   <= sum_y_next;
    end

    // ---------------- rounding stage ----------------
    logic signed [65:0] rnd_x_full;
    logic signed [65:0] rnd_y_full;

    logic               rd_valid_reg;
    prt_pkg::item_t     rd_item_reg;
    logic signed [35:0] rnd_x_reg;
    logic signed [35:0] rnd_y_reg;

    assign rnd_x_full = (sum_x_reg + HALF_Q30) >>> 30;
    assign rnd_y_full = (sum_y_reg + HALF_Q30) >>> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= sm_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_item_reg <= sm_item_reg;
        rnd_x_reg   <= rnd_x_full[35:0];
        rnd_y_reg   <= rnd_y_full[35:0];
    end

    // ---------------- offset and clip stage ----------------
    logic signed [36:0] fin_x;
    logic signed [36:0] fin_y;
    logic               hi_x;
    logic               lo_x;
    logic               hi_y;
    logic               lo_y;
    logic signed [31:0] out_x_next;
    logic signed [31:0] out_y_next;
    logic [15:0]        out_angle_next;
    logic               sat_next;

    logic               done_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic [15:0]        out_angle_reg;
    logic               sat_reg;

    always_comb
    begin
        case (rd_item_reg.op)
            prt_pkg::OP_APPLY:
            begin
                fin_x = 37'(rnd_x_reg) + 37'(rd_item_reg.ax);
                fin_y = 37'(rnd_y_reg) + 37'(rd_item_reg.ay);
            end
            prt_pkg::OP_RELATIVE:
            begin
                fin_x = 37'(rd_item_reg.bx) - 37'(rnd_x_reg);
                fin_y = 37'(rd_item_reg.by) - 37'(rnd_y_reg);
            end
            prt_pkg::OP_INVERT:
            begin
                fin_x = 37'(rnd_x_reg);
                fin_y = 37'(rnd_y_reg);
            end
            default:
            begin
                fin_x = '0;
                fin_y = '0;
            end
        endcase

        hi_x = !fin_x[36] && (|fin_x[35:31]);
        lo_x = fin_x[36] && !(&fin_x[35:31]);
        hi_y = !fin_y[36] && (|fin_y[35:31]);
        lo_y = fin_y[36] && !(&fin_y[35:31]);

        if (hi_x)
            out_x_next = 32'sh7FFFFFFF;
        else if (lo_x)
            out_x_next = 32'sh80000000;
        else
            out_x_next = fin_x[31:0];

        if (hi_y)
            out_y_next = 32'sh7FFFFFFF;
        else if (lo_y)
            out_y_next = 32'sh80000000;
        else
            out_y_next = fin_y[31:0];

        out_angle_next = rd_item_reg.angle;
        sat_next       = hi_x || lo_x || hi_y || lo_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_angle_reg <= out_angle_next;
        sat_reg       <= sat_next;
    end

    assign done      = done_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_angle = out_angle_reg;
    assign saturated = sat_reg;

    // ---------------- assertions ----------------
    a_result_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction produced no result at the expected cycle");

    a_result_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching accepted transaction");

    a_unused_opcode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(opcode == prt_pkg::OP_NONE, LATENCY)) |->
        (out_x == 32'sd0 && out_y == 32'sd0 && out_angle == 16'd0 && !saturated))
        else $error("unused opcode returned a nonzero result");

    a_saturation_clips: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
        (out_x == 32'sh7FFFFFFF || out_x == 32'sh80000000 ||
         out_y == 32'sh7FFFFFFF || out_y == 32'sh80000000))
        else $error("saturation flag set without a clipped coordinate");

endmodule
